FILE: design/pdth_pkg.sv
`default_nettype none
package pdth_pkg;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] REG_DEAD_TIME = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_HITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EVENT_MODE = 2'd2;

  localparam logic [19:0] DEAD_TIME_RST = 20'd30000;
  localparam logic [12:0] MAX_HITS_RST = 13'd65;

  localparam logic [12:0] PMT_CNT_MAX = 13'h1fff;
  localparam logic [7:0] CONTRIB_MAX = 8'hff;

  localparam logic OP_HIT = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  typedef struct packed {
    logic [19:0] dead_time;
    logic [12:0] max_hits;
    logic        event_mode;
  } cfg_t;

endpackage
`default_nettype wire

FILE: design/pdth_ram.sv
`default_nettype none
module pdth_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: design/pdth_cfg.sv
`default_nettype none
module pdth_cfg (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [pdth_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [pdth_pkg::CFG_DATA_W-1:0]   cfg_data,
  output pdth_pkg::cfg_t                         cfg
);

  pdth_pkg::cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dead_time <= pdth_pkg::DEAD_TIME_RST;
      cfg_r.max_hits <= pdth_pkg::MAX_HITS_RST;
      cfg_r.event_mode <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        pdth_pkg::REG_DEAD_TIME: cfg_r.dead_time <= cfg_data;
        pdth_pkg::REG_MAX_HITS: cfg_r.max_hits <= cfg_data[12:0];
        pdth_pkg::REG_EVENT_MODE: cfg_r.event_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: design/pixel_dead_time_hit_merger.sv
`default_nettype none
// channel | direction | handshake              | payload
// in      | input     | in_valid / in_ready    | op, pixel_address, pmt_id, hit_time
// out     | output    | out_valid / out_ready  | hit_accepted, digi_*, drain_done
// cfg     | input     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// a hit goes through memory read, time difference, check and write back, result
// a drain reads and checks each pixel from the cursor onward, and for a present one also its pmt count;
// the scan runs over one pixel memory port
// drain done, and reset, start a clearing pass over max(NUM_PIXELS, NUM_PMTS) entries,
// during which no word is taken; done is reported after the pass
// a new word is taken while the previous result waits in the output register
module pixel_dead_time_hit_merger #(
  parameter int NUM_PIXELS = 4096,
  parameter int NUM_PMTS = 64,
  parameter int TIME_BITS = 48
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic                                in_op,
  input  wire logic [11:0]                         in_pixel_address,
  input  wire logic [5:0]                          in_pmt_id,
  input  wire logic [TIME_BITS-1:0]                in_hit_time,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic                                     out_hit_accepted,
  output logic                                     out_digi_valid,
  output logic [11:0]                              out_digi_pixel,
  output logic [5:0]                               out_digi_pmt,
  output logic [TIME_BITS-1:0]                     out_digi_time,
  output logic [7:0]                               out_digi_contributions,
  output logic                                     out_drain_done,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [pdth_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [pdth_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int PIX_W = $clog2(NUM_PIXELS);
  localparam int PMT_W = (NUM_PMTS > 1) ? $clog2(NUM_PMTS) : 1;
  localparam int CUR_W = $clog2(NUM_PIXELS + 1);
  localparam int CLR_LEN = (NUM_PIXELS > NUM_PMTS) ? NUM_PIXELS : NUM_PMTS;
  localparam int CLR_W = $clog2(CLR_LEN);
  localparam int AW = 1 + TIME_BITS;
  localparam int BW = 1 + 8 + PMT_W + TIME_BITS;
  localparam int DW = ((TIME_BITS > 20) ? TIME_BITS : 20) + 1;

  typedef enum logic [2:0] {
    ST_CLR, ST_IDLE, ST_HIT_CHK, ST_HIT_WR, ST_DRN_RD, ST_DRN_CHK, ST_DRN_CNT, ST_FIN
  } state_t;

  state_t state_r;
  pdth_pkg::cfg_t cfg;

  logic             clr_all_r;
  logic [CLR_W-1:0] clr_idx_r;
  logic [CUR_W-1:0] cursor_r;

  logic [PIX_W-1:0]     pix_r;
  logic [PMT_W-1:0]     pmt_r;
  logic [TIME_BITS-1:0] t_r;
  logic [DW-1:0]        diff_r;
  logic                 fired_r;
  logic [BW-1:0]        bq_r;
  logic [12:0]          pcnt_r;

  logic                 res_acc_r, res_dv_r, res_done_r;
  logic [11:0]          res_pix_r;
  logic [5:0]           res_pmt_r;
  logic [TIME_BITS-1:0] res_time_r;
  logic [7:0]           res_cnt_r;

  logic                 out_valid_r, out_acc_r, out_dv_r, out_done_r;
  logic [11:0]          out_pix_r;
  logic [5:0]           out_pmt_r;
  logic [TIME_BITS-1:0] out_time_r;
  logic [7:0]           out_cnt_r;

  logic             a_we, b_we, c_we;
  logic [PIX_W-1:0] a_waddr, b_waddr, a_raddr, b_raddr;
  logic [PMT_W-1:0] c_waddr, c_raddr;
  logic [AW-1:0]    a_wdata, a_rdata;
  logic [BW-1:0]    b_wdata, b_rdata;
  logic [12:0]      c_wdata, c_rdata;

  logic [PMT_W-1:0] pmt_in_mod;
  logic [DW-1:0]    dt_ext, diff_sum;
  logic             near, accept, clr_last, clr_pix, clr_pmt, slot_free, out_load;
  logic [7:0]       cnt_inc;

  pdth_cfg u_cfg (
    .clk(clk), .rst_n(rst_n), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .cfg(cfg)
  );

  // fired flag and last fire time
  pdth_ram #(.WIDTH(AW), .DEPTH(NUM_PIXELS)) u_fire_ram (
    .clk(clk), .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
    .raddr(a_raddr), .rdata(a_rdata)
  );

  // digi: present, count, pmt, first time
  pdth_ram #(.WIDTH(BW), .DEPTH(NUM_PIXELS)) u_digi_ram (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
    .raddr(b_raddr), .rdata(b_rdata)
  );

  pdth_ram #(.WIDTH(13), .DEPTH(NUM_PMTS)) u_pmt_ram (
    .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
    .raddr(c_raddr), .rdata(c_rdata)
  );

  // small table for pmt id modulo pmt count
  always_comb begin
    pmt_in_mod = '0;
    for (int i = 0; i < 64; i++) begin
      if (in_pmt_id == 6'(i)) begin
        pmt_in_mod = PMT_W'(i % NUM_PMTS);
      end
    end
  end

  assign in_ready = (state_r == ST_IDLE);
  assign slot_free = !out_valid_r || out_ready;
  assign out_load = (state_r == ST_FIN) && slot_free;
  assign clr_last = (clr_idx_r == CLR_W'(CLR_LEN - 1));
  assign clr_pix = (32'(clr_idx_r) < NUM_PIXELS);
  assign clr_pmt = (32'(clr_idx_r) < NUM_PMTS);

  // |t - last| < dead_time; negative diff checked as diff + dead_time > 0
  assign dt_ext = DW'(cfg.dead_time);
  assign diff_sum = diff_r + dt_ext;
  assign near = diff_r[DW-1] ? (!diff_sum[DW-1] && (diff_sum != '0)) : (diff_r < dt_ext);
  assign accept = !(fired_r && !cfg.event_mode && near);
  assign cnt_inc = (bq_r[BW-2 -: 8] == pdth_pkg::CONTRIB_MAX) ? bq_r[BW-2 -: 8]
                                                             : bq_r[BW-2 -: 8] + 8'd1;

  always_comb begin
    a_raddr = PIX_W'(in_pixel_address);
    b_raddr = (state_r == ST_DRN_RD) ? cursor_r[PIX_W-1:0] : PIX_W'(in_pixel_address);
    c_raddr = (state_r == ST_DRN_CHK) ? b_rdata[TIME_BITS +: PMT_W] : pmt_in_mod;
    a_we = 1'b0;
    a_waddr = pix_r;
    a_wdata = {1'b1, t_r};
    b_we = 1'b0;
    b_waddr = pix_r;
    b_wdata = bq_r;
    c_we = 1'b0;
    c_waddr = pmt_r;
    c_wdata = pcnt_r + 13'd1;
    case (state_r)
      ST_CLR: begin
        a_we = clr_all_r && clr_pix;
        a_waddr = clr_idx_r[PIX_W-1:0];
        a_wdata = '0;
        b_we = clr_pix;
        b_waddr = clr_idx_r[PIX_W-1:0];
        b_wdata = '0;
        c_we = clr_pmt;
        c_waddr = clr_idx_r[PMT_W-1:0];
        c_wdata = '0;
      end
      ST_HIT_WR: begin
        a_we = 1'b1;
        b_we = accept;
        if (bq_r[BW-1]) begin
          b_wdata = {1'b1, cnt_inc, bq_r[TIME_BITS +: PMT_W], bq_r[TIME_BITS-1:0]};
        end else begin
          b_wdata = {1'b1, 8'd1, pmt_r, t_r};
        end
        c_we = accept && !bq_r[BW-1] && (pcnt_r != pdth_pkg::PMT_CNT_MAX);
      end
      ST_DRN_CHK: begin
        b_we = b_rdata[BW-1];
        b_waddr = cursor_r[PIX_W-1:0];
        b_wdata = {1'b0, b_rdata[BW-2:0]};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
      clr_all_r <= 1'b1;
      clr_idx_r <= '0;
      cursor_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_CLR: begin
          if (clr_last) begin
            clr_idx_r <= '0;
            clr_all_r <= 1'b0;
            state_r <= clr_all_r ? ST_IDLE : ST_FIN;
          end else begin
            clr_idx_r <= clr_idx_r + 1'b1;
          end
        end
        ST_IDLE: begin
          res_acc_r <= 1'b0;
          res_dv_r <= 1'b0;
          res_done_r <= 1'b0;
          res_pix_r <= '0;
          res_pmt_r <= '0;
          res_time_r <= '0;
          res_cnt_r <= '0;
          pix_r <= PIX_W'(in_pixel_address);
          pmt_r <= pmt_in_mod;
          t_r <= in_hit_time;
          if (in_valid) begin
            if (in_op == pdth_pkg::OP_DRAIN) begin
              state_r <= ST_DRN_RD;
            end else if (32'(in_pixel_address) >= NUM_PIXELS) begin
              state_r <= ST_FIN;
            end else begin
              state_r <= ST_HIT_CHK;
            end
          end
        end
        ST_HIT_CHK: begin
          diff_r <= DW'(t_r) - DW'(a_rdata[TIME_BITS-1:0]);
          fired_r <= a_rdata[AW-1];
          bq_r <= b_rdata;
          pcnt_r <= c_rdata;
          state_r <= ST_HIT_WR;
        end
        ST_HIT_WR: begin
          res_acc_r <= accept;
          state_r <= ST_FIN;
        end
        ST_DRN_RD: begin
          if (32'(cursor_r) >= NUM_PIXELS) begin
            res_done_r <= 1'b1;
            res_pix_r <= '0;
            res_pmt_r <= '0;
            res_time_r <= '0;
            res_cnt_r <= '0;
            cursor_r <= '0;
            clr_idx_r <= '0;
            state_r <= ST_CLR;
          end else begin
            state_r <= ST_DRN_CHK;
          end
        end
        ST_DRN_CHK: begin
          res_pix_r <= 12'(cursor_r);
          res_pmt_r <= 6'(b_rdata[TIME_BITS +: PMT_W]);
          res_time_r <= b_rdata[TIME_BITS-1:0];
          res_cnt_r <= b_rdata[BW-2 -: 8];
          if (b_rdata[BW-1]) begin
            state_r <= ST_DRN_CNT;
          end else begin
            cursor_r <= cursor_r + 1'b1;
            state_r <= ST_DRN_RD;
          end
        end
        ST_DRN_CNT: begin
          cursor_r <= cursor_r + 1'b1;
          // crowded pmt: drop the digi and keep scanning
          if (c_rdata > cfg.max_hits) begin
            state_r <= ST_DRN_RD;
          end else begin
            res_dv_r <= 1'b1;
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (slot_free) begin
            out_acc_r <= res_acc_r;
            out_dv_r <= res_dv_r;
            out_done_r <= res_done_r;
            out_pix_r <= res_pix_r;
            out_pmt_r <= res_pmt_r;
            out_time_r <= res_time_r;
            out_cnt_r <= res_cnt_r;
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_hit_accepted = out_acc_r;
  assign out_digi_valid = out_dv_r;
  assign out_drain_done = out_done_r;
  assign out_digi_pixel = out_pix_r;
  assign out_digi_pmt = out_pmt_r;
  assign out_digi_time = out_time_r;
  assign out_digi_contributions = out_cnt_r;

`ifndef NO_ASSERTIONS
  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_hit_accepted && (out_digi_valid || out_drain_done))
      && !(out_digi_valid && out_drain_done))
    else $error("result carries more than one kind");

  a_clr_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLR) |-> !in_ready)
    else $error("word taken during clearing pass");

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cursor_r) <= NUM_PIXELS)
    else $error("drain cursor out of range");

  a_hit_path: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_op == pdth_pkg::OP_HIT)
      |=> (state_r == ST_HIT_CHK || state_r == ST_FIN))
    else $error("hit took a wrong path");
`endif

endmodule
`default_nettype wire

FILE: tb/pixel_dead_time_hit_merger_test.sv
`default_nettype none
module pixel_dead_time_hit_merger_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NPIX = 4096;
  localparam int NPMT = 64;
  localparam logic [47:0] TMAX = 48'hffff_ffff_ffff;
  localparam int STALL_LIMIT = 200000;

  typedef struct packed {
    logic        hit_ok;
    logic        dvalid;
    logic [11:0] pixel;
    logic [5:0]  pmt;
    logic [47:0] first_tm;
    logic [7:0]  contrib;
    logic        done;
  } merge_result_t;

  class merger_scoreboard;
    bit          fired[NPIX];
    logic [47:0] last_tm[NPIX];
    bit          present[NPIX];
    logic [47:0] first_tm[NPIX];
    logic [7:0]  contrib[NPIX];
    logic [5:0]  digi_pmt[NPIX];
    logic [12:0] pmt_cnt[NPMT];
    int          cursor;
    logic [19:0] dead_time;
    logic [12:0] max_hits;
    logic        event_mode;
    merge_result_t pending_q[$];
    int          errors;

    function new();
      dead_time = pdth_pkg::DEAD_TIME_RST;
      max_hits = pdth_pkg::MAX_HITS_RST;
      event_mode = 1'b0;
      cursor = 0;
      errors = 0;
      foreach (fired[i]) begin
        fired[i] = 0;
        present[i] = 0;
      end
      foreach (pmt_cnt[i]) pmt_cnt[i] = '0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [19:0] val);
      case (idx)
        pdth_pkg::REG_DEAD_TIME: dead_time = val;
        pdth_pkg::REG_MAX_HITS: max_hits = val[12:0];
        pdth_pkg::REG_EVENT_MODE: event_mode = val[0];
        default: ;
      endcase
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    function merge_result_t note_word(logic op, logic [11:0] addr, logic [5:0] pmt,
                                      logic [47:0] t);
      merge_result_t r;
      logic [47:0] dt;
      bit ok;
      r = '0;
      if (op == pdth_pkg::OP_HIT) begin
        ok = 1;
        if (!event_mode && fired[addr]) begin
          dt = (t >= last_tm[addr]) ? t - last_tm[addr] : last_tm[addr] - t;
          if (dt < {28'd0, dead_time}) ok = 0;
        end
        if (ok) begin
          if (!present[addr]) begin
            present[addr] = 1;
            first_tm[addr] = t;
            contrib[addr] = 8'd1;
            digi_pmt[addr] = pmt;
            if (pmt_cnt[pmt] != pdth_pkg::PMT_CNT_MAX) pmt_cnt[pmt]++;
          end else if (contrib[addr] != pdth_pkg::CONTRIB_MAX) begin
            contrib[addr]++;
          end
        end
        fired[addr] = 1;
        last_tm[addr] = t;
        r.hit_ok = ok;
      end else begin
        r.done = 1;
        for (int a = cursor; a < NPIX; a++) begin
          if (!present[a]) continue;
          present[a] = 0;
          if (pmt_cnt[digi_pmt[a]] > max_hits) continue;
          r.done = 0;
          r.dvalid = 1;
          r.pixel = a[11:0];
          r.pmt = digi_pmt[a];
          r.first_tm = first_tm[a];
          r.contrib = contrib[a];
          cursor = a + 1;
          break;
        end
        if (r.done) begin
          foreach (present[i]) present[i] = 0;
          foreach (pmt_cnt[i]) pmt_cnt[i] = '0;
          cursor = 0;
        end
      end
      pending_q.push_back(r);
      return r;
    endfunction

    task check_word(merge_result_t got);
      merge_result_t exp;
      if (pending_q.size() == 0) begin
        report("result word with nothing expected");
        return;
      end
      exp = pending_q.pop_front();
      if (got.hit_ok !== exp.hit_ok)
        report($sformatf("hit_accepted %0b, want %0b", got.hit_ok, exp.hit_ok));
      if (got.dvalid !== exp.dvalid)
        report($sformatf("digi_valid %0b, want %0b", got.dvalid, exp.dvalid));
      if (got.pixel !== exp.pixel)
        report($sformatf("digi_pixel %0d, want %0d", got.pixel, exp.pixel));
      if (got.pmt !== exp.pmt)
        report($sformatf("digi_pmt %0d, want %0d", got.pmt, exp.pmt));
      if (got.first_tm !== exp.first_tm)
        report($sformatf("digi_time %0h, want %0h", got.first_tm, exp.first_tm));
      if (got.contrib !== exp.contrib)
        report($sformatf("contributions %0d, want %0d", got.contrib, exp.contrib));
      if (got.done !== exp.done)
        report($sformatf("drain_done %0b, want %0b", got.done, exp.done));
    endtask
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  logic in_op = 0;
  logic [11:0] in_pixel_address = '0;
  logic [5:0] in_pmt_id = '0;
  logic [47:0] in_hit_time = '0;
  logic out_valid;
  logic out_ready = 0;
  logic out_hit_accepted, out_digi_valid, out_drain_done;
  logic [11:0] out_digi_pixel;
  logic [5:0] out_digi_pmt;
  logic [47:0] out_digi_time;
  logic [7:0] out_digi_contributions;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [pdth_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [pdth_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  merger_scoreboard sb = new();
  bit hold_req = 0;
  int idle_cycles = 0;

  pixel_dead_time_hit_merger uut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // result monitor and watchdog
  initial begin
    forever begin
      @(posedge clk);
      if (out_valid && out_ready)
        sb.check_word({out_hit_accepted, out_digi_valid, out_digi_pixel, out_digi_pmt,
                       out_digi_time, out_digi_contributions, out_drain_done});
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready) ||
          !rst_n)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 0;
        hold_req = 0;
        for (n = 0; n < 400; n++) @(negedge clk);
      end
      case ($urandom_range(0, 9))
        0: out_ready = 0;
        1: begin
          out_ready = 0;
          repeat ($urandom_range(1, 40)) @(negedge clk);
        end
        default: out_ready = 1;
      endcase
    end
  end

  task send_word(logic op, logic [11:0] addr, logic [5:0] pmt, logic [47:0] t,
                 output merge_result_t r);
    int gap;
    gap = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid = 1;
    in_op = op;
    in_pixel_address = addr;
    in_pmt_id = pmt;
    in_hit_time = t;
    do @(posedge clk); while (!in_ready);
    r = sb.note_word(op, addr, pmt, t);
  endtask

  task hit(logic [11:0] addr, logic [5:0] pmt, logic [47:0] t);
    merge_result_t r;
    send_word(pdth_pkg::OP_HIT, addr, pmt, t, r);
  endtask

  task drain_all();
    merge_result_t r;
    do send_word(pdth_pkg::OP_DRAIN, 12'($urandom), 6'($urandom),
                 48'({$urandom, $urandom}), r);
    while (!r.done);
  endtask

  task wait_results();
    @(negedge clk);
    in_valid = 0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (30) @(negedge clk);
  endtask

  task write_reg(logic [1:0] idx, logic [19:0] val);
    wait_results();
    @(negedge clk);
    cfg_valid = 1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_valid = 0;
  endtask

  task run_event(int nhits);
    logic [47:0] tbase;
    logic [11:0] base;
    logic [5:0] pmt_base;
    int span, pool;
    merge_result_t r;
    tbase = 48'({$urandom, $urandom}) & 48'hffff_ffc0_0000;
    case ($urandom_range(0, 2))
      0: base = 0;
      1: base = 12'd4080;
      default: base = 12'($urandom);
    endcase
    pool = $urandom_range(2, 15);
    pmt_base = 6'($urandom);
    span = 3 * sb.dead_time + 10;
    for (int i = 0; i < nhits; i++) begin
      if ($urandom_range(0, 6) == 0)
        send_word(pdth_pkg::OP_DRAIN, 0, 0, 0, r);
      else if ($urandom_range(0, 9) == 0)
        hit(12'($urandom), 6'($urandom), 48'({$urandom, $urandom}));
      else
        hit(base + 12'($urandom_range(0, pool)), pmt_base + 6'($urandom_range(0, 2)),
            tbase + 48'($urandom_range(0, span)));
    end
    drain_all();
  endtask

  initial begin
    logic [19:0] dt_pick;
    rst_n = 0;
    repeat (4) @(negedge clk);
    rst_n = 1;

    // directed: dead-time edges, pmt kept, drain behind cursor, empty drain
    hit(0, 0, 0);
    hit(0, 0, 48'd29999);
    hit(0, 0, 48'd59999);
    hit(0, 0, 48'd59998);
    hit(12'd4095, 6'd63, TMAX);
    hit(12'd4095, 6'd5, TMAX - 48'd30000);
    hit(12'd100, 6'd1, 48'd1000);
    begin
      merge_result_t r;
      send_word(pdth_pkg::OP_DRAIN, 0, 0, 0, r);
      hit(12'd50, 6'd2, 48'd5);
      send_word(pdth_pkg::OP_DRAIN, 0, 0, 0, r);
    end
    drain_all();
    drain_all();
    write_reg(pdth_pkg::REG_EVENT_MODE, 20'd1);
    hit(0, 0, 48'd59998);
    hit(0, 0, 48'd59998);
    write_reg(pdth_pkg::REG_MAX_HITS, 20'd1);
    hit(12'd7, 6'd9, 48'h5555_5555_5555);
    hit(12'd8, 6'd9, 48'haaaa_aaaa_aaaa);
    hit(12'd9, 6'd10, 48'd3);
    drain_all();
    write_reg(pdth_pkg::REG_MAX_HITS, 20'd0);
    write_reg(pdth_pkg::REG_DEAD_TIME, 20'd0);
    write_reg(pdth_pkg::REG_EVENT_MODE, 20'd0);
    hit(12'd2, 6'd3, 48'd10);
    hit(12'd2, 6'd3, 48'd10);
    drain_all();

    // saturate contributions while the receiver holds off
    write_reg(pdth_pkg::REG_MAX_HITS, 20'd4096);
    write_reg(pdth_pkg::REG_EVENT_MODE, 20'd1);
    hold_req = 1;
    for (int i = 0; i < 260; i++) hit(12'd1234, 6'd33, 48'($urandom));
    drain_all();
    wait_results();

    for (int ev = 0; ev < 8; ev++) begin
      case ($urandom_range(0, 3))
        0: dt_pick = 0;
        1: dt_pick = 20'd1000000;
        default: dt_pick = 20'($urandom_range(0, 100000));
      endcase
      write_reg(pdth_pkg::REG_DEAD_TIME, dt_pick);
      case ($urandom_range(0, 4))
        0: write_reg(pdth_pkg::REG_MAX_HITS, 20'd0);
        1: write_reg(pdth_pkg::REG_MAX_HITS, 20'd4096);
        default: write_reg(pdth_pkg::REG_MAX_HITS, 20'($urandom_range(1, 6)));
      endcase
      write_reg(pdth_pkg::REG_EVENT_MODE, ($urandom_range(0, 3) == 0) ? 20'd1 : 20'd0);
      run_event($urandom_range(10, 30));
    end

    wait_results();
    repeat (100) @(negedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end
endmodule
`default_nettype wire
